### sv/mtc_pkg.sv
package mtc_pkg;

  localparam int IM_W   = 18;
  localparam int MZ_W   = 32;
  localparam int CH_W   = 5;
  localparam int GAS_W  = 16;
  localparam int COEF_W = 32;
  localparam int CCS_W  = 23;

  localparam int MASS_W = 36;   // mz * charge, charge below 16
  localparam int IMCH_W = 21;   // positive im (17 bits) * charge (4 bits)
  localparam int PROD_W = 52;   // mass * gas_mass
  localparam int DEN_W  = 37;   // mass + gas16
  localparam int RED_W  = 24;   // reduced mass, Q.16
  localparam int ROOT_W = 28;   // sqrt(reduced << 32), Q.24
  localparam int NUM_W  = 53;   // im * charge * coef
  localparam int DVD_W  = 56;   // num * 4 + root / 2

  localparam int CFG_IDX_W = 1;

  localparam logic [GAS_W-1:0]  GAS_RST  = 16'd7168;
  localparam logic [COEF_W-1:0] COEF_RST = 32'd69443417;
  localparam logic [CCS_W-1:0]  CCS_MAX  = 23'h7FFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAS_MASS = 1'b0,
    REG_CCS_COEF = 1'b1
  } cfg_reg_t;

endpackage

### sv/mtc_front.sv
module mtc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [mtc_pkg::IM_W-1:0]      im,
  input  logic [mtc_pkg::MZ_W-1:0]      mz,
  input  logic [mtc_pkg::CH_W-1:0]      ch,
  input  logic [mtc_pkg::GAS_W-1:0]     gas,
  output logic                          out_valid,
  output logic                          out_bad,
  output logic [mtc_pkg::PROD_W-1:0]    out_prod,
  output logic [mtc_pkg::DEN_W-1:0]     out_den,
  output logic [mtc_pkg::IMCH_W-1:0]    out_imch
);

  logic                          v1_r, v2_r;
  logic                          bad1_r, bad2_r;
  logic [mtc_pkg::MASS_W-1:0]    mass1_r;
  logic [mtc_pkg::IMCH_W-1:0]    imch1_r, imch2_r;
  logic [mtc_pkg::PROD_W-1:0]    prod2_r;
  logic [mtc_pkg::DEN_W-1:0]     den2_r;
  logic                          bad_nxt;

  always_comb begin
    bad_nxt = im[mtc_pkg::IM_W-1] || (im == '0) || ch[mtc_pkg::CH_W-1] || (ch == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad1_r  <= bad_nxt;
      mass1_r <= mtc_pkg::MASS_W'(mz * ch[3:0]);
      imch1_r <= mtc_pkg::IMCH_W'(im[16:0] * ch[3:0]);
      bad2_r  <= bad1_r;
      prod2_r <= mtc_pkg::PROD_W'(mass1_r * gas);
      den2_r  <= {1'b0, mass1_r} + {13'b0, gas, 8'b0};
      imch2_r <= imch1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_bad   = bad2_r;
  assign out_prod  = prod2_r;
  assign out_den   = den2_r;
  assign out_imch  = imch2_r;

endmodule

### sv/mtc_udiv.sv
// Restoring divider, one quotient bit per stage. in_rem must be below in_div.
module mtc_udiv #(
  parameter int QW = 24,
  parameter int DW = 37,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_lo,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_q,
  output logic [SW-1:0] out_side
);

  logic [QW-1:0] v_r;
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] lo_r   [QW];
  logic [QW-1:0] q_r    [QW];
  logic [DW-1:0] div_r  [QW];
  logic [SW-1:0] side_r [QW];

  function automatic logic [DW:0] div_step(logic [DW-1:0] rem, logic b, logic [DW-1:0] d);
    logic [DW:0] t;
    logic [DW:0] s;
    t = {rem, b};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) return {s[DW-1:0], 1'b1};
    return {t[DW-1:0], 1'b0};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        if (k == 0) begin
          {rem_r[k], q_r[k][0]} <= div_step(in_rem, in_lo[QW-1], in_div);
          q_r[k][QW-1:1] <= '0;
          lo_r[k]   <= {in_lo[QW-2:0], 1'b0};
          div_r[k]  <= in_div;
          side_r[k] <= in_side;
        end else begin
          {rem_r[k], q_r[k][0]} <= div_step(rem_r[k-1], lo_r[k-1][QW-1], div_r[k-1]);
          q_r[k][QW-1:1] <= q_r[k-1][QW-2:0];
          lo_r[k]   <= {lo_r[k-1][QW-2:0], 1'b0};
          div_r[k]  <= div_r[k-1];
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

### sv/mtc_isqrt.sv
// Digit-by-digit square root of reduced << 32, one root bit per stage.
module mtc_isqrt #(
  parameter int SW = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [mtc_pkg::RED_W-1:0]    in_rad,
  input  logic [SW-1:0]                in_side,
  output logic                         out_valid,
  output logic [mtc_pkg::ROOT_W-1:0]   out_root,
  output logic [SW-1:0]                out_side
);

  localparam int N  = mtc_pkg::ROOT_W;
  localparam int RW = N + 1;
  localparam int XW = mtc_pkg::RED_W;

  logic [N-1:0]  v_r;
  logic [RW-1:0] rem_r  [N];
  logic [N-1:0]  root_r [N];
  logic [XW-1:0] rad_r  [N];
  logic [SW-1:0] side_r [N];

  function automatic logic [RW:0] sq_step(logic [RW-1:0] rem, logic [1:0] pr,
                                          logic [N-1:0] root);
    logic [RW+1:0] t;
    logic [RW+1:0] trial;
    logic [RW+1:0] s;
    t     = {rem, pr};
    trial = {1'b0, root, 2'b01};
    s     = t - trial;
    if (t >= trial) return {s[RW-1:0], 1'b1};
    return {t[RW-1:0], 1'b0};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        if (k == 0) begin
          {rem_r[k], root_r[k][0]} <= sq_step('0, in_rad[XW-1:XW-2], '0);
          root_r[k][N-1:1] <= '0;
          rad_r[k]  <= {in_rad[XW-3:0], 2'b00};
          side_r[k] <= in_side;
        end else begin
          {rem_r[k], root_r[k][0]} <= sq_step(rem_r[k-1], rad_r[k-1][XW-1:XW-2],
                                              root_r[k-1]);
          root_r[k][N-1:1] <= root_r[k-1][N-2:0];
          rad_r[k]  <= {rad_r[k-1][XW-3:0], 2'b00};
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

### sv/mtc_scale.sv
// Numerator product, then rounding add and overflow check against root << 24.
module mtc_scale (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         in_bad,
  input  logic [mtc_pkg::IMCH_W-1:0]   in_imch,
  input  logic [mtc_pkg::ROOT_W-1:0]   in_root,
  input  logic [mtc_pkg::COEF_W-1:0]   coef,
  output logic                         out_valid,
  output logic                         out_bad,
  output logic                         out_ovf,
  output logic [mtc_pkg::DVD_W-1:0]    out_dvd,
  output logic [mtc_pkg::ROOT_W-1:0]   out_root
);

  logic                        va_r, vb_r;
  logic                        bada_r, badb_r;
  logic [mtc_pkg::NUM_W-1:0]   num_r;
  logic [mtc_pkg::ROOT_W-1:0]  roota_r, rootb_r;
  logic [mtc_pkg::DVD_W-1:0]   dvd_nxt, dvd_r;
  logic                        ovf_r;

  always_comb begin
    dvd_nxt = {1'b0, num_r, 2'b00} + {29'b0, roota_r[mtc_pkg::ROOT_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bada_r  <= in_bad;
      num_r   <= mtc_pkg::NUM_W'(in_imch * coef);
      roota_r <= in_root;
      badb_r  <= bada_r;
      dvd_r   <= dvd_nxt;
      rootb_r <= roota_r;
      // quotient would need 24 or more bits; also catches a zero root
      ovf_r   <= dvd_nxt[55:24] >= {4'b0, roota_r};
    end
  end

  assign out_valid = vb_r;
  assign out_bad   = badb_r;
  assign out_ovf   = ovf_r;
  assign out_dvd   = dvd_r;
  assign out_root  = rootb_r;

endmodule

### sv/mobility_to_cross_section.sv
// Pipeline from an accepted input word to its result word: front, reduced-mass divider,
// square root, scale, final divider, output register.
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// Reset (rst_n low, synchronous): pipeline valid bits and output valid clear,
// gas_mass returns to 28.0 and ccs_coefficient to 1059.62245.
module mobility_to_cross_section (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [55:0]                       in_tdata,   // mobility, precursor_mz, charge
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,  // ccs_value
  output logic [1:0]                        out_tuser,  // converted, saturated
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  logic [mtc_pkg::GAS_W-1:0]   gas_r;
  logic [mtc_pkg::COEF_W-1:0]  coef_r;
  logic                        en;

  logic                        f_valid, f_bad;
  logic [mtc_pkg::PROD_W-1:0]  f_prod;
  logic [mtc_pkg::DEN_W-1:0]   f_den;
  logic [mtc_pkg::IMCH_W-1:0]  f_imch;

  logic                        d1_valid;
  logic [mtc_pkg::RED_W-1:0]   d1_q, reduced;
  logic [22:0]                 d1_side;

  logic                        s_valid;
  logic [mtc_pkg::ROOT_W-1:0]  s_root;
  logic [21:0]                 s_side;

  logic                        c_valid, c_bad, c_ovf;
  logic [mtc_pkg::DVD_W-1:0]   c_dvd;
  logic [mtc_pkg::ROOT_W-1:0]  c_root;

  logic                        d2_valid;
  logic [mtc_pkg::RED_W-1:0]   d2_q;
  logic [1:0]                  d2_side;

  logic                        out_valid_r;
  logic [mtc_pkg::CCS_W-1:0]   ccs_r, ccs_nxt;
  logic                        conv_r, sat_r, sat_nxt;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_r  <= mtc_pkg::GAS_RST;
      coef_r <= mtc_pkg::COEF_RST;
    end else if (cfg_valid) begin
      case (mtc_pkg::cfg_reg_t'(cfg_index))
        mtc_pkg::REG_GAS_MASS: gas_r  <= cfg_data[15:0];
        mtc_pkg::REG_CCS_COEF: coef_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mtc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .im       (in_tdata[17:0]),
    .mz       (in_tdata[49:18]),
    .ch       (in_tdata[54:50]),
    .gas      (gas_r),
    .out_valid(f_valid),
    .out_bad  (f_bad),
    .out_prod (f_prod),
    .out_den  (f_den),
    .out_imch (f_imch)
  );

  // reduced = (prod << 8) / den; top 36 dividend bits are below den
  mtc_udiv #(.QW(mtc_pkg::RED_W), .DW(mtc_pkg::DEN_W), .SW(23)) u_div_red (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (f_valid),
    .in_rem   ({1'b0, f_prod[51:16]}),
    .in_lo    ({f_prod[15:0], 8'b0}),
    .in_div   (f_den),
    .in_side  ({f_bad, f_den == '0, f_imch}),
    .out_valid(d1_valid),
    .out_q    (d1_q),
    .out_side (d1_side)
  );

  assign reduced = d1_side[21] ? '0 : d1_q;

  mtc_isqrt #(.SW(22)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (d1_valid),
    .in_rad   (reduced),
    .in_side  ({d1_side[22], d1_side[20:0]}),
    .out_valid(s_valid),
    .out_root (s_root),
    .out_side (s_side)
  );

  mtc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s_valid),
    .in_bad   (s_side[21]),
    .in_imch  (s_side[20:0]),
    .in_root  (s_root),
    .coef     (coef_r),
    .out_valid(c_valid),
    .out_bad  (c_bad),
    .out_ovf  (c_ovf),
    .out_dvd  (c_dvd),
    .out_root (c_root)
  );

  mtc_udiv #(.QW(mtc_pkg::RED_W), .DW(mtc_pkg::ROOT_W), .SW(2)) u_div_ccs (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (c_valid),
    .in_rem   (c_dvd[51:24]),
    .in_lo    (c_dvd[23:0]),
    .in_div   (c_root),
    .in_side  ({c_bad, c_ovf}),
    .out_valid(d2_valid),
    .out_q    (d2_q),
    .out_side (d2_side)
  );

  always_comb begin
    sat_nxt = !d2_side[1] && (d2_side[0] || d2_q[23]);
    if (d2_side[1]) begin
      ccs_nxt = '0;
    end else if (sat_nxt) begin
      ccs_nxt = mtc_pkg::CCS_MAX;
    end else begin
      ccs_nxt = d2_q[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ccs_r  <= ccs_nxt;
      conv_r <= !d2_side[1];
      sat_r  <= sat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, ccs_r};
  assign out_tuser  = {sat_r, conv_r};

endmodule

### test/mobility_to_cross_section_test.sv
`timescale 1ns / 1ps

module mobility_to_cross_section_test;

  typedef struct packed {
    logic [mtc_pkg::CH_W-1:0] charge;
    logic [mtc_pkg::MZ_W-1:0] mz;
    logic [mtc_pkg::IM_W-1:0] im;
  } meas_t;

  typedef struct {
    logic [mtc_pkg::CCS_W-1:0] ccs;
    logic                      conv;
    logic                      sat;
  } ccs_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mtc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  mobility_to_cross_section u_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  logic [mtc_pkg::GAS_W-1:0]  gas_q = mtc_pkg::GAS_RST;
  logic [mtc_pkg::COEF_W-1:0] coef_q = mtc_pkg::COEF_RST;
  meas_t    meas_q[$];
  ccs_res_t ccs_q[$];
  int errors = 0;
  longint cycles = 0;
  bit calm = 1'b0;   // stretch with no idling
  bit feeding = 1'b0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic ccs_res_t predict_ccs(input meas_t m);
    ccs_res_t res;
    logic [63:0] mass, gas16, den, red, root, num, ccs;
    logic [63:0] ch, imv;
    res = '{ccs: '0, conv: 1'b0, sat: 1'b0};
    if (m.im[mtc_pkg::IM_W-1] || m.im == 0 || m.charge[mtc_pkg::CH_W-1] || m.charge == 0)
      return res;
    ch = 64'(m.charge);
    imv = 64'(m.im);
    mass = 64'(m.mz) * ch;
    gas16 = 64'(gas_q) << 8;
    den = mass + gas16;
    red = (den == 0) ? 64'd0 : (mass * gas16) / den;
    root = int_sqrt(red << 32);
    res.conv = 1'b1;
    if (root == 0) begin
      res.ccs = mtc_pkg::CCS_MAX;
      res.sat = 1'b1;
      return res;
    end
    num = imv * ch * 64'(coef_q);
    ccs = ((num << 2) + (root >> 1)) / root;
    if (ccs > 64'(mtc_pkg::CCS_MAX)) begin
      res.ccs = mtc_pkg::CCS_MAX;
      res.sat = 1'b1;
    end else begin
      res.ccs = ccs[mtc_pkg::CCS_W-1:0];
    end
    return res;
  endfunction

  function automatic meas_t rand_meas();
    meas_t m;
    logic [31:0] r_im, r_ch;
    r_im = $urandom;
    r_ch = $urandom;
    m.im = r_im[mtc_pkg::IM_W-1:0];
    m.mz = $urandom;
    m.charge = r_ch[mtc_pkg::CH_W-1:0];
    case ($urandom_range(0, 9))
      0: ;                                   // anything goes
      1: m.mz = $urandom_range(0, 3);        // tiny reduced mass
      default: begin
        r_im = $urandom_range(1, 131071);
        r_ch = $urandom_range(1, 15);
        m.im = r_im[mtc_pkg::IM_W-1:0];
        m.charge = r_ch[mtc_pkg::CH_W-1:0];
        m.mz = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(65536 * 100, 65536 * 3000);
      end
    endcase
    return m;
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ccs_q.insert(ccs_q.size(), predict_ccs(meas_t'(in_tdata[54:0])));
      meas_q.pop_front();
    end
    if (rst_n && feeding && meas_q.size() != 0) begin
      if (in_tvalid && !in_tready) begin
        // hold word
      end else if (calm || $urandom_range(0, 99) >= 17) begin
        in_tvalid <= 1'b1;
        in_tdata <= {1'b0, meas_q[0]};
      end else begin
        in_tvalid <= 1'b0;
      end
    end else if (!(in_tvalid && !in_tready)) begin
      in_tvalid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= calm || $urandom_range(0, 99) >= 17;
    if (out_tvalid && out_tready) begin
      if (ccs_q.size() == 0) begin
        $display("%0t unexpected word: expected none, actual ccs=%0d user=%b",
                 $time, out_tdata, out_tuser);
        errors <= errors + 1;
      end else begin
        if (out_tdata[mtc_pkg::CCS_W-1:0] !== ccs_q[0].ccs || out_tdata[23] !== 1'b0 ||
            out_tuser !== {ccs_q[0].sat, ccs_q[0].conv}) begin
          $display("%0t mismatch: expected ccs=%0d conv=%b sat=%b, actual ccs=%0d user=%b",
                   $time, ccs_q[0].ccs, ccs_q[0].conv, ccs_q[0].sat, out_tdata, out_tuser);
          errors <= errors + 1;
        end
        ccs_q.pop_front();
      end
    end
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input mtc_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mtc_pkg::REG_GAS_MASS) gas_q = val[mtc_pkg::GAS_W-1:0];
    else coef_q = val;
  endtask

  task automatic run_phase(input int n_rand);
    meas_t m;
    for (int i = 0; i < n_rand; i++) begin
      m = rand_meas();
      meas_q.insert(meas_q.size(), m);
    end
    feeding = 1'b1;
    while (meas_q.size() != 0 || in_tvalid) @(posedge clk);
    feeding = 1'b0;
    while (ccs_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    meas_t m;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: field extremes and the unconverted / unbounded cases
    m = '{charge: 5'd2, mz: 32'd65536 * 500, im: 18'd16384};  meas_q.insert(meas_q.size(), m);
    m = '{charge: 5'd15, mz: 32'hFFFFFFFF, im: 18'h1FFFF};    meas_q.insert(meas_q.size(), m);
    m = '{charge: 5'd1, mz: 32'd65536 * 500, im: 18'd1};      meas_q.insert(meas_q.size(), m);
    m = '{charge: 5'd1, mz: 32'd65536 * 500, im: 18'd0};      meas_q.insert(meas_q.size(), m);
    m = '{charge: 5'd1, mz: 32'd65536 * 500, im: 18'h20000};  meas_q.insert(meas_q.size(), m);
    m = '{charge: 5'd1, mz: 32'd65536 * 500, im: 18'h3FFFF};  meas_q.insert(meas_q.size(), m);
    m = '{charge: 5'd0, mz: 32'd65536 * 500, im: 18'd16384};  meas_q.insert(meas_q.size(), m);
    m = '{charge: 5'h1F, mz: 32'd65536 * 500, im: 18'd16384}; meas_q.insert(meas_q.size(), m);
    m = '{charge: 5'h10, mz: 32'hFFFFFFFF, im: 18'h1FFFF};    meas_q.insert(meas_q.size(), m);
    m = '{charge: 5'd3, mz: 32'd0, im: 18'd16384};            meas_q.insert(meas_q.size(), m);
    m = '{charge: 5'd1, mz: 32'd1, im: 18'd16384};            meas_q.insert(meas_q.size(), m);
    run_phase(300);
    calm = 1'b1;
    write_reg(mtc_pkg::REG_GAS_MASS, 32'd65535);
    write_reg(mtc_pkg::REG_CCS_COEF, 32'hFFFFFFFF);
    run_phase(300);
    calm = 1'b0;
    write_reg(mtc_pkg::REG_GAS_MASS, 32'd256);
    write_reg(mtc_pkg::REG_CCS_COEF, 32'd1);
    run_phase(300);
    write_reg(mtc_pkg::REG_CCS_COEF, 32'd0);
    m = '{charge: 5'd3, mz: 32'd0, im: 18'd100}; meas_q.insert(meas_q.size(), m);
    run_phase(200);
    write_reg(mtc_pkg::REG_GAS_MASS, 32'd0);
    write_reg(mtc_pkg::REG_CCS_COEF, 32'd69443417);
    run_phase(100);
    write_reg(mtc_pkg::REG_GAS_MASS, 32'd7168);
    run_phase(400);
    if (errors == 0 && ccs_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### mobility_to_cross_section.f
sv/mtc_pkg.sv
sv/mtc_front.sv
sv/mtc_udiv.sv
sv/mtc_isqrt.sv
sv/mtc_scale.sv
sv/mobility_to_cross_section.sv
test/mobility_to_cross_section_test.sv
